// ----- hw/rtl/pcd_pkg.sv -----
// Shared types and constants for the periodic convection-diffusion step block.
// Used by the channel interfaces, the controller, the datapath and the top level.
package pcd_pkg;

  localparam int DATA_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int MODE_W     = 2;
  localparam int IDX_W      = 10;
  localparam int MAX_POINTS = 1024;
  localparam int CNT_W      = $clog2(MAX_POINTS);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 16;

  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = 18;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int FRAC_SHIFT = 29;
  localparam int Q_W        = SUM_W - FRAC_SHIFT;

  localparam logic [CFG_IDX_W-1:0] CFG_ADVECT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd2;

  localparam logic [MODE_W-1:0] MODE_UPWIND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LAX    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AV,
    S_CONV,
    S_DIFF,
    S_SUM,
    S_PUT,
    S_PASS1,
    S_PASS0
  } pcd_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_AV,
    OP_CONV,
    OP_DIFF,
    OP_SUM
  } pcd_op_e;

  typedef enum logic [1:0] {
    ST_MID,
    ST_TAIL,
    ST_WRAP
  } pcd_stencil_e;

  typedef enum logic [1:0] {
    SRC_CALC,
    SRC_W2,
    SRC_HEAD
  } pcd_src_e;

  typedef enum logic [1:0] {
    IDX_PREV,
    IDX_CUR,
    IDX_ONE,
    IDX_ZERO
  } pcd_idx_e;

  typedef struct packed {
    logic         shift;
    pcd_op_e      op;
    pcd_stencil_e stencil;
    logic         out_load;
    pcd_src_e     out_src;
    pcd_idx_e     out_idx;
    logic         out_final;
  } pcd_cmd_t;

  typedef struct packed {
    logic out_free;
    logic in_last;
    logic cnt_ge2;
    logic cnt_one;
  } pcd_status_t;

endpackage

// ----- hw/rtl/pcd_in_if.sv -----
// Input channel of the convection-diffusion step block: one grid point per request.
// Depends on pcd_pkg for the field widths.
interface pcd_in_if import pcd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample;
  logic signed [DATA_W-1:0] velocity;
  logic                     line_end;

  modport source (output valid, output sample, output velocity, output line_end,
                  input ready);
  modport sink (input valid, input sample, input velocity, input line_end,
                output ready);
endinterface

// ----- hw/rtl/pcd_out_if.sv -----
// Output channel of the convection-diffusion step block: one updated point per request.
// Depends on pcd_pkg for the field widths.
interface pcd_out_if import pcd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] new_value;
  logic [IDX_W-1:0]         point_index;
  logic                     final_result;

  modport source (output valid, output new_value, output point_index,
                  output final_result, input ready);
  modport sink (input valid, input new_value, input point_index, input final_result,
                output ready);
endinterface

// ----- hw/rtl/pcd_ctrl.sv -----
// Controller of the convection-diffusion step block: sequences the shared multiplier,
// the final sum and the result loads. Depends on pcd_pkg.
module pcd_ctrl import pcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pcd_status_t st_i,
  output pcd_cmd_t    cmd_o
);

  pcd_state_e   state_q, state_d;
  pcd_stencil_e job_q, job_d;
  logic         last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      job_q   <= ST_MID;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    job_d             = job_q;
    last_d            = last_q;
    in_ready_o        = 1'b0;
    cmd_o             = '0;
    cmd_o.op          = OP_NONE;
    cmd_o.stencil     = job_q;
    cmd_o.out_src     = SRC_CALC;
    cmd_o.out_idx     = IDX_PREV;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.shift = 1'b1;
          last_d      = st_i.in_last;
          if (st_i.cnt_ge2) begin
            job_d   = ST_MID;
            state_d = S_AV;
          end else if (st_i.in_last && st_i.cnt_one) begin
            state_d = S_PASS1;
          end else if (st_i.in_last) begin
            state_d = S_PASS0;
          end
        end
      end
      S_AV: begin
        cmd_o.op = OP_AV;
        state_d  = S_CONV;
      end
      S_CONV: begin
        cmd_o.op = OP_CONV;
        state_d  = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.op = OP_DIFF;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = S_PUT;
      end
      S_PUT: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          unique case (job_q)
            ST_MID: begin
              cmd_o.out_idx = IDX_PREV;
              if (last_q) begin
                job_d   = ST_TAIL;
                state_d = S_AV;
              end else begin
                state_d = S_IDLE;
              end
            end
            ST_TAIL: begin
              cmd_o.out_idx = IDX_CUR;
              job_d         = ST_WRAP;
              state_d       = S_AV;
            end
            ST_WRAP: begin
              cmd_o.out_idx   = IDX_ZERO;
              cmd_o.out_final = 1'b1;
              state_d         = S_IDLE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_PASS1: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = SRC_W2;
          cmd_o.out_idx  = IDX_ONE;
          state_d        = S_PASS0;
        end
      end
      S_PASS0: begin
        if (st_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_src   = SRC_HEAD;
          cmd_o.out_idx   = IDX_ZERO;
          cmd_o.out_final = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> st_i.out_free)
    else $error("Result loaded while the output register is still occupied.");

  a_mul_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AV) |=> (state_q == S_CONV))
    else $error("Convection product did not follow the gain product.");

  a_single_point_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.shift && st_i.in_last && !st_i.cnt_ge2 && !st_i.cnt_one)
      |=> (state_q == S_PASS0))
    else $error("One-point line did not go straight to its final result.");

  a_wrap_after_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT && job_q == ST_TAIL && st_i.out_free) |=> (job_q == ST_WRAP))
    else $error("Wraparound point was not scheduled after the last point.");
`endif

endmodule

// ----- hw/rtl/pcd_datapath.sv -----
// Datapath of the convection-diffusion step block: point window, configuration,
// shared 34x18 multiplier, rounding sum and output register. Depends on pcd_pkg.
module pcd_datapath import pcd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  input  logic signed [DATA_W-1:0] in_sample_i,
  input  logic signed [DATA_W-1:0] in_velocity_i,
  input  logic                     in_line_end_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic signed [DATA_W-1:0] new_value_o,
  output logic [IDX_W-1:0]         point_index_o,
  output logic                     final_result_o,
  input  pcd_cmd_t                 cmd_i,
  output pcd_status_t              st_o
);

  logic [GAIN_W-1:0]        adv_q, dif_q;
  logic [MODE_W-1:0]        mode_q;
  logic signed [DATA_W-1:0] w0_q, w1_q, w2_q, wv0_q, wv1_q, h0_q, h1_q, hv_q;
  logic [CNT_W-1:0]         cnt_q, cur_q;
  logic signed [32:0]       av_q;
  logic signed [PROD_W-1:0] conv_q, diff_q;
  logic signed [DATA_W-1:0] res_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic [IDX_W-1:0]         out_idx_q;
  logic                     out_final_q;

  logic signed [DATA_W-1:0]  op_l, op_c, op_r, op_v;
  logic signed [17:0]        d2;
  logic signed [16:0]        du;
  logic signed [16:0]        rl_sum;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [SUM_W-1:0]   base, conv_x, diff_x, total;
  logic signed [Q_W-1:0]     q;
  logic signed [DATA_W-1:0]  sat;
  logic                      in_last;
  logic [IDX_W-1:0]          idx_sel;

  assign in_last = in_line_end_i || (cnt_q == CNT_W'(MAX_POINTS - 1));

  assign st_o.out_free = !out_valid_q || out_ready_i;
  assign st_o.in_last  = in_last;
  assign st_o.cnt_ge2  = cnt_q >= CNT_W'(2);
  assign st_o.cnt_one  = cnt_q == CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adv_q  <= '0;
      dif_q  <= '0;
      mode_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ADVECT:  adv_q  <= GAIN_W'(cfg_wdata_i);
        CFG_DIFFUSE: dif_q  <= GAIN_W'(cfg_wdata_i);
        CFG_MODE:    mode_q <= cfg_wdata_i[MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w0_q  <= '0;
      w1_q  <= '0;
      w2_q  <= '0;
      wv0_q <= '0;
      wv1_q <= '0;
      h0_q  <= '0;
      h1_q  <= '0;
      hv_q  <= '0;
      cnt_q <= '0;
      cur_q <= '0;
    end else if (cmd_i.shift) begin
      w0_q  <= w1_q;
      w1_q  <= w2_q;
      w2_q  <= in_sample_i;
      wv0_q <= wv1_q;
      wv1_q <= in_velocity_i;
      if (cnt_q == CNT_W'(0)) begin
        h0_q <= in_sample_i;
        hv_q <= in_velocity_i;
      end
      if (cnt_q == CNT_W'(1)) begin
        h1_q <= in_sample_i;
      end
      cur_q <= cnt_q;
      cnt_q <= in_last ? '0 : cnt_q + CNT_W'(1);
    end
  end

  always_comb begin
    unique case (cmd_i.stencil)
      ST_MID: begin
        op_l = w0_q;
        op_c = w1_q;
        op_r = w2_q;
        op_v = wv0_q;
      end
      ST_TAIL: begin
        op_l = w1_q;
        op_c = w2_q;
        op_r = h0_q;
        op_v = wv1_q;
      end
      ST_WRAP: begin
        op_l = w2_q;
        op_c = h0_q;
        op_r = h1_q;
        op_v = hv_q;
      end
      default: begin
        op_l = w0_q;
        op_c = w1_q;
        op_r = w2_q;
        op_v = wv0_q;
      end
    endcase
  end

  assign d2     = 18'(op_r) - (18'(op_c) <<< 1) + 18'(op_l);
  assign rl_sum = 17'(op_r) + 17'(op_l);

  always_comb begin
    if (mode_q == MODE_UPWIND) begin
      du = op_v[DATA_W-1] ? (17'(op_r) - 17'(op_c)) : (17'(op_c) - 17'(op_l));
    end else begin
      du = 17'(op_r) - 17'(op_l);
    end
  end

  always_comb begin
    unique case (cmd_i.op)
      OP_AV: begin
        mul_a = MUL_A_W'(adv_q);
        mul_b = MUL_B_W'(op_v);
      end
      OP_CONV: begin
        mul_a = MUL_A_W'(av_q);
        mul_b = MUL_B_W'(du);
      end
      OP_DIFF: begin
        mul_a = MUL_A_W'(dif_q);
        mul_b = d2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    if (mode_q == MODE_LAX) begin
      base = SUM_W'(rl_sum) <<< (FRAC_SHIFT - 1);
    end else begin
      base = SUM_W'(op_c) <<< FRAC_SHIFT;
    end
    conv_x = (mode_q == MODE_UPWIND) ? (SUM_W'(conv_q) <<< 1) : SUM_W'(conv_q);
    diff_x = SUM_W'(diff_q) <<< 13;
    total  = base - conv_x + diff_x + (SUM_W'(1) <<< (FRAC_SHIFT - 1));
    q      = total[SUM_W-1:FRAC_SHIFT];
    if (q[Q_W-1:DATA_W-1] == '0 || q[Q_W-1:DATA_W-1] == '1) begin
      sat = q[DATA_W-1:0];
    end else begin
      sat = q[Q_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_AV:   av_q   <= mul_p[32:0];
      OP_CONV: conv_q <= mul_p;
      OP_DIFF: diff_q <= mul_p;
      OP_SUM:  res_q  <= sat;
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (cmd_i.out_idx)
      IDX_PREV: idx_sel = IDX_W'(cur_q - CNT_W'(1));
      IDX_CUR:  idx_sel = IDX_W'(cur_q);
      IDX_ONE:  idx_sel = IDX_W'(1);
      IDX_ZERO: idx_sel = '0;
      default:  idx_sel = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      unique case (cmd_i.out_src)
        SRC_CALC: out_value_q <= res_q;
        SRC_W2:   out_value_q <= w2_q;
        SRC_HEAD: out_value_q <= h0_q;
        default:  out_value_q <= res_q;
      endcase
      out_idx_q   <= idx_sel;
      out_final_q <= cmd_i.out_final;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign new_value_o    = out_value_q;
  assign point_index_o  = out_idx_q;
  assign final_result_o = out_final_q;

`ifndef SYNTH
  a_count_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.shift && in_last) |=> (cnt_q == '0))
    else $error("Point count did not restart after the last point of a line.");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(out_ready_i))
    else $error("Result dropped before it was taken.");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i)
      |=> ($stable(out_value_q) && $stable(out_idx_q) && $stable(out_final_q)))
    else $error("Result changed while it was waiting to be taken.");
`endif

endmodule

// ----- hw/rtl/periodic_convect_diffuse_step.sv -----
// Top level of the periodic convection-diffusion step block.
// Depends on pcd_pkg, pcd_in_if, pcd_out_if, pcd_ctrl and pcd_datapath.

// The block advances a periodic line of Q4.12 points by one explicit time step, one point
// per input request, and returns each updated point with its grid index; point 0 comes last
// and is marked final. Points 0 and 1 are taken from the idle state; when one of them closes
// a short line, its points pass unchanged to the output register. Every later point is
// shifted into the window, goes through the single shared 34x18 multiplier (gain times
// velocity, convection product, diffusion product) and the rounding sum, and is then loaded
// into the output register. The closing point of a line of three or more adds two more
// passes for the wraparound points. A result waits in an output register, so the next point
// is taken while it is still unread; a stalled output stalls the following result. Gains and
// mode must be written only while no line is in flight; the block does not enforce this.
module periodic_convect_diffuse_step import pcd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  pcd_in_if.sink               in_i,
  pcd_out_if.source            out_o
);

  pcd_cmd_t    cmd;
  pcd_status_t st;

  pcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  pcd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_sample_i    (in_i.sample),
    .in_velocity_i  (in_i.velocity),
    .in_line_end_i  (in_i.line_end),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .new_value_o    (out_o.new_value),
    .point_index_o  (out_o.point_index),
    .final_result_o (out_o.final_result),
    .cmd_i          (cmd),
    .st_o           (st)
  );

endmodule

// ----- bench/tb_periodic_convect_diffuse_step.sv -----
`timescale 1ns / 100ps
// Testbench for periodic_convect_diffuse_step: streams grid lines through the block and
// compares every updated point against an in-bench model of the explicit time step.
// Depends on pcd_pkg, pcd_in_if, pcd_out_if and the RTL of the block.
module tb_periodic_convect_diffuse_step;
  import pcd_pkg::*;

  localparam logic [MODE_W-1:0] MODE_CENTRAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;
  localparam longint HALF_STEP  = 64'sd268435456;
  localparam longint FULL_STEP  = 64'sd536870912;
  localparam int     DRAIN_CYC  = 40;
  localparam int     RANDOM_PTS = 480;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;
    logic                     is_last;
  } point_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  pcd_in_if  in_if ();
  pcd_out_if out_if ();

  periodic_convect_diffuse_step dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  logic [GAIN_W-1:0] adv_gain;
  logic [GAIN_W-1:0] dif_gain;
  logic [MODE_W-1:0] scheme;
  longint            win_val [3];
  longint            win_vel [2];
  longint            head_val [2];
  longint            head_vel;
  int unsigned       pt_count;

  point_result_t expected_points [$];

  int src_max_gap;
  int sink_max_stall;
  int points_sent;
  int lines_closed;
  int results_checked;
  int mismatch_cnt;
  int lines_in_mode [4];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic signed [DATA_W-1:0] ftcs_update(input longint left, input longint mid,
                                                           input longint right, input longint vel);
    longint a;
    longint b;
    longint diff;
    longint conv;
    longint base;
    longint q;
    a = adv_gain;
    b = dif_gain;
    diff = b * (right - 2 * mid + left) * 8192;
    if (scheme == MODE_UPWIND) begin
      conv = a * vel * ((vel >= 0) ? (mid - left) : (right - mid)) * 2;
    end else begin
      conv = a * vel * (right - left);
    end
    if (scheme == MODE_LAX) begin
      base = (right + left) * HALF_STEP;
    end else begin
      base = mid * FULL_STEP;
    end
    q = (base - conv + diff + HALF_STEP) >>> FRAC_SHIFT;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return DATA_W'(q);
  endfunction

  function automatic void push_point(input logic signed [DATA_W-1:0] value,
                                     input int unsigned idx, input logic is_last);
    point_result_t r;
    r.value = value;
    r.index = idx[IDX_W-1:0];
    r.is_last = is_last;
    expected_points.push_back(r);
  endfunction

  function automatic void predict_point(input logic signed [DATA_W-1:0] s,
                                        input logic signed [DATA_W-1:0] v, input logic le);
    int unsigned c;
    logic        closing;
    c = pt_count;
    closing = le || (c + 1 >= MAX_POINTS);
    win_val[0] = win_val[1];
    win_val[1] = win_val[2];
    win_val[2] = s;
    win_vel[0] = win_vel[1];
    win_vel[1] = v;
    if (c == 0) begin
      head_val[0] = s;
      head_vel = v;
    end
    if (c == 1) head_val[1] = s;
    if (c >= 2) push_point(ftcs_update(win_val[0], win_val[1], win_val[2], win_vel[0]),
                           c - 1, 1'b0);
    if (closing) begin
      if (c >= 2) begin
        push_point(ftcs_update(win_val[1], win_val[2], head_val[0], win_vel[1]), c, 1'b0);
        push_point(ftcs_update(win_val[2], head_val[0], head_val[1], head_vel), 0, 1'b1);
      end else if (c == 1) begin
        push_point(DATA_W'(win_val[2]), 1, 1'b0);
        push_point(DATA_W'(head_val[0]), 0, 1'b1);
      end else begin
        push_point(DATA_W'(head_val[0]), 0, 1'b1);
      end
      pt_count = 0;
      lines_closed++;
      lines_in_mode[scheme]++;
    end else begin
      pt_count = c + 1;
    end
  endfunction

  task automatic send_point(input logic signed [DATA_W-1:0] s,
                            input logic signed [DATA_W-1:0] v, input logic le);
    int gap;
    gap = $urandom_range(src_max_gap, 0);
    repeat (gap) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid    <= 1'b1;
    in_if.sample   <= s;
    in_if.velocity <= v;
    in_if.line_end <= le;
    do @(posedge clk); while (!in_if.ready);
    predict_point(s, v, le);
    points_sent++;
  endtask

  task automatic send_line(input int len, input bit smooth, input bit wide_vel,
                           input bit mark_end);
    int                       walk;
    int                       k;
    logic signed [DATA_W-1:0] s;
    logic signed [DATA_W-1:0] v;
    walk = int'($urandom_range(16383, 0)) - 8192;
    for (k = 0; k < len; k++) begin
      if (smooth) begin
        walk += int'($urandom_range(1023, 0)) - 512;
        if (walk > 30000) walk = 30000;
        if (walk < -30000) walk = -30000;
        s = walk[DATA_W-1:0];
      end else begin
        s = DATA_W'($urandom);
      end
      v = wide_vel ? DATA_W'($urandom) : DATA_W'(int'($urandom_range(8191, 0)) - 4096);
      send_point(s, v, mark_end && (k == len - 1));
    end
  endtask

  task automatic drain;
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ADVECT:  adv_gain = data;
      CFG_DIFFUSE: dif_gain = data;
      CFG_MODE:    scheme = data[MODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_scheme(input logic [GAIN_W-1:0] adv, input logic [GAIN_W-1:0] dif,
                            input logic [MODE_W-1:0] mode);
    drain();
    write_reg(CFG_ADVECT, adv);
    write_reg(CFG_DIFFUSE, dif);
    write_reg(CFG_MODE, CFG_W'(mode));
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(4, 0))
      0: return '0;
      1: return '1;
      2: return GAIN_W'($urandom_range(2047, 0));
      3: return GAIN_W'($urandom_range(8191, 0));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  task automatic test_short_lines;
    send_point(16'sh7fff, -16'sh8000, 1'b1);
    send_point(-16'sh8000, 16'sh7fff, 1'b1);
    send_point(16'sh1234, -16'sh0001, 1'b0);
    send_point(-16'sh0001, 16'sh0000, 1'b1);
  endtask

  task automatic test_each_mode;
    logic [MODE_W-1:0] modes [4];
    int                m;
    modes = '{MODE_CENTRAL, MODE_UPWIND, MODE_LAX, MODE_SPARE};
    for (m = 0; m < 4; m++) begin
      set_scheme(16'h4000, 16'h2000, modes[m]);
      send_point(16'sh1000, 16'sh0800, 1'b0);
      send_point(16'sh3000, -16'sh1000, 1'b0);
      send_point(-16'sh2000, 16'sh2000, 1'b0);
      send_point(16'sh0400, -16'sh0400, 1'b1);
    end
  endtask

  task automatic test_saturation;
    set_scheme('1, '1, MODE_CENTRAL);
    send_point(16'sh7fff, -16'sh8000, 1'b0);
    send_point(-16'sh8000, 16'sh7fff, 1'b0);
    send_point(16'sh7fff, -16'sh8000, 1'b1);
  endtask

  task automatic test_random_lines;
    int start;
    int n;
    int sel;
    int len;
    start = points_sent;
    while (points_sent - start < RANDOM_PTS) begin
      set_scheme(pick_gain(), pick_gain(), MODE_W'($urandom_range(3, 0)));
      src_max_gap    = ($urandom_range(3, 0) == 0) ? 0 : 10;
      sink_max_stall = ($urandom_range(3, 0) == 0) ? 0 : 10;
      for (n = $urandom_range(6, 2); n > 0; n--) begin
        sel = $urandom_range(19, 0);
        if (sel < 3) len = $urandom_range(2, 1);
        else if (sel < 17) len = $urandom_range(16, 3);
        else len = $urandom_range(40, 17);
        send_line(len, $urandom_range(2, 0) != 0, 1'($urandom_range(1, 0)), 1'b1);
      end
    end
    src_max_gap = 10;
    sink_max_stall = 10;
  endtask

  task automatic test_overlong_line;
    set_scheme(GAIN_W'($urandom_range(4095, 0)), GAIN_W'($urandom_range(16383, 0)),
               MODE_W'($urandom_range(3, 0)));
    src_max_gap = 0;
    send_line(MAX_POINTS, 1'b1, 1'b0, 1'b0);
    src_max_gap = 10;
    send_line(2, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic test_pressure;
    set_scheme(GAIN_W'($urandom_range(8191, 0)), GAIN_W'($urandom_range(8191, 0)),
               MODE_UPWIND);
    send_line(5, 1'b1, 1'b1, 1'b0);
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    send_line(3, 1'b1, 1'b1, 1'b1);
  endtask

  initial begin
    point_result_t  want;
    int             stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    fork
      forever begin
        stall = $urandom_range(sink_max_stall, 0);
        repeat (stall) begin
          @(negedge clk);
          out_if.ready <= 1'b0;
        end
        @(negedge clk);
        out_if.ready <= 1'b1;
        do @(posedge clk); while (!out_if.valid);
      end
      forever begin
        @(posedge clk);
        if (out_if.valid && out_if.ready) begin
          results_checked++;
          if (expected_points.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("tb: unexpected result value=%0d index=%0d last=%0b",
                       out_if.new_value, out_if.point_index, out_if.final_result);
            end
          end else begin
            want = expected_points.pop_front();
            if (out_if.new_value !== want.value || out_if.point_index !== want.index ||
                out_if.final_result !== want.is_last) begin
              mismatch_cnt++;
              if (mismatch_cnt <= 10) begin
                $display("tb: mismatch expected value=%0d index=%0d last=%0b, got %0d %0d %0b",
                         want.value, want.index, want.is_last, out_if.new_value,
                         out_if.point_index, out_if.final_result);
              end
            end
          end
        end
      end
    join
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.sample   = '0;
    in_if.velocity = '0;
    in_if.line_end = 1'b0;
    adv_gain       = '0;
    dif_gain       = '0;
    scheme         = MODE_CENTRAL;
    win_val        = '{0, 0, 0};
    win_vel        = '{0, 0};
    head_val       = '{0, 0};
    head_vel       = 0;
    pt_count       = 0;
    src_max_gap    = 10;
    sink_max_stall = 10;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_short_lines();
    test_each_mode();
    test_saturation();
    test_random_lines();
    test_overlong_line();
    test_pressure();
    drain();

    $display("tb: %0d points in %0d lines, %0d results checked, %0d mismatches",
             points_sent, lines_closed, results_checked, mismatch_cnt);
    $display("tb: lines per mode central %0d, upwind %0d, lax %0d, spare %0d",
             lines_in_mode[0], lines_in_mode[1], lines_in_mode[2], lines_in_mode[3]);
    if (mismatch_cnt == 0 && expected_points.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- periodic_convect_diffuse_step.f -----
hw/rtl/pcd_pkg.sv
hw/rtl/pcd_in_if.sv
hw/rtl/pcd_out_if.sv
hw/rtl/pcd_ctrl.sv
hw/rtl/pcd_datapath.sv
hw/rtl/periodic_convect_diffuse_step.sv
bench/tb_periodic_convect_diffuse_step.sv
